>>> rtl/ordered_list_insert_delete_core_macros.svh
// Assertion macros for the core RTL file, which checks its own logic.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_MACROS_SVH

// When the condition holds in a cycle, the consequence holds in the same cycle.
`define OLID_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// When the condition holds in a cycle, the consequence holds in the next cycle.
`define OLID_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/olid_pkg.sv
package olid_pkg;

    // Number of cells in the list.
    localparam int DEPTH = 16;
    // Count holds 0..DEPTH, a cell index holds 0..DEPTH-1.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    // Fixed field widths of the ports.
    localparam int POS_W = 5;
    localparam int DATA_W = 32;
    // Width in which position and count are compared.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_DEL_FRONT = 2'd1,
        OP_DEL_BACK  = 2'd2,
        OP_DEL_POS   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Shift command broadcast to every cell.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] idx;
    } t_cmd;

endpackage

>>> rtl/olid_cell.sv
module olid_cell (
    input  logic                         i_clk,
    input  olid_pkg::t_cmd               i_cmd,
    input  logic [olid_pkg::IDX_W-1:0]   i_index,
    input  logic signed [olid_pkg::DATA_W-1:0] i_prev,
    input  logic signed [olid_pkg::DATA_W-1:0] i_next,
    output logic signed [olid_pkg::DATA_W-1:0] o_value
);
    import olid_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    // An insert shifts every entry one cell back; a delete pulls the entries
    // at and behind the removed one a cell forward.
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            n_value = i_prev;
        end else if (i_cmd.del && (i_index >= i_cmd.idx)) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> rtl/olid_dec.sv
module olid_dec (
    input  olid_pkg::t_op                i_op,
    input  logic [olid_pkg::POS_W-1:0]   i_position,
    input  logic [olid_pkg::CNT_W-1:0]   i_count,
    output olid_pkg::t_cmd               o_cmd,
    output olid_pkg::t_status            o_status,
    output logic [olid_pkg::CNT_W-1:0]   o_count
);
    import olid_pkg::*;

    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic [IDX_W-1:0] w_last;

    assign w_pos  = CMP_W'(i_position);
    assign w_cnt  = CMP_W'(i_count);
    assign w_last = IDX_W'(i_count - CNT_W'(1));

    // Check the operation against the fill level, pick the cell to remove or flag an insert, and give the new count.
    always_comb begin
        o_cmd    = '0;
        o_status = ST_OK;
        o_count  = i_count;
        if (i_op == OP_INS_FRONT) begin
            if (i_count >= CNT_W'(DEPTH)) begin
                o_status = ST_FULL;
            end else begin
                o_cmd.ins = 1'b1;
                o_count   = i_count + CNT_W'(1);
            end
        end else if (i_count == '0) begin
            o_status = ST_EMPTY;
        end else begin
            case (i_op)
                OP_DEL_FRONT: begin
                    o_cmd.del = 1'b1;
                    o_cmd.idx = '0;
                end
                OP_DEL_BACK: begin
                    o_cmd.del = 1'b1;
                    o_cmd.idx = w_last;
                end
                default: begin
                    if ((w_pos == '0) || (w_pos > w_cnt)) begin
                        o_status = ST_BADPOS;
                    end else begin
                        o_cmd.del = 1'b1;
                        o_cmd.idx = IDX_W'(w_pos - CMP_W'(1));
                    end
                end
            endcase
            if (o_cmd.del) begin
                o_count = i_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/ordered_list_insert_delete_core.sv
// Ordered list of signed 32-bit values kept front first in a row of cells.
// Input channel: i_in_valid / o_in_stall carry one beat of op, value and
// position. Output channel: o_out_valid / i_out_stall carry one beat of
// status, removed value and count after the operation, one per input beat.
// Every operation is settled in the cycle it is accepted: all cells shift in
// parallel, so the result beat appears in the cycle after the input beat and a
// new beat can be accepted in every cycle, one item per cycle sustained, unless
// the receiver stalls a held result. The rate is set by the single output
// register: the input is stalled only while a result beat is held there and
// the receiver stalls, and a held beat keeps its value until it is taken.
// A synchronous active-low reset empties the list and drops any pending
// result; the cell contents are not cleared, as only cells below the count
// are ever read. A failed operation leaves the list unchanged and returns a
// status of empty, full or bad position with a removed value of zero.
`include "ordered_list_insert_delete_core_macros.svh"

module ordered_list_insert_delete_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic signed [olid_pkg::DATA_W-1:0]  i_value,
    input  logic [olid_pkg::POS_W-1:0]          i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic signed [olid_pkg::DATA_W-1:0]  o_removed_value,
    output logic [olid_pkg::POS_W-1:0]          o_count
);
    import olid_pkg::*;

    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_removed;

    logic                     w_accept;
    t_cmd                     w_cmd;
    t_cmd                     w_cell_cmd;
    t_status                  w_status;
    logic signed [DATA_W-1:0] w_removed;
    logic signed [DATA_W-1:0] w_val [DEPTH];
    logic [CMP_W-1:0]         w_cnt_ext;

    // Handshake: take a beat unless a held result is stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    olid_dec u_dec (
        .i_op       (t_op'(i_op)),
        .i_position (i_position),
        .i_count    (r_cnt),
        .o_cmd      (w_cmd),
        .o_status   (w_status),
        .o_count    (n_cnt)
    );

    // Cells move only on an accepted beat.
    assign w_cell_cmd = w_accept ? w_cmd : '0;

    // Row of cells; each takes from its front or back neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = i_value;
        end else begin : g_mid
            assign w_prev = w_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_val[g];
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end
        olid_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cell_cmd),
            .i_index (IDX_W'(g)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_val[g])
        );
    end

    // Pick the value leaving the list; zero when nothing is removed.
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_cmd.del && (w_cmd.idx == IDX_W'(k))) begin
                w_removed = w_val[k];
            end
        end
    end

    // Output register and count.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= w_status;
            r_removed <= w_removed;
        end
    end

    assign w_cnt_ext       = CMP_W'(r_cnt);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_count         = w_cnt_ext[POS_W-1:0];

    // Self checks.
    `OLID_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(DEPTH))
    `OLID_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, w_accept && w_cmd.ins, r_cnt == $past(r_cnt) + CNT_W'(1))
    `OLID_ASSERT_NEXT(a_fail_keeps, i_clk, i_rst_n, w_accept && (w_status != ST_OK), $stable(r_cnt))
    `OLID_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, r_out_valid && (r_status != ST_OK), r_removed == '0)

endmodule

>>> tb/sv/ordered_list_insert_delete_core_test.sv
`timescale 1ns / 100ps

module ordered_list_insert_delete_core_test;
    import olid_pkg::*;

    // One result beat as the list should report it.
    typedef struct {
        t_status                   status;
        logic signed [DATA_W-1:0]  removed;
        logic [POS_W-1:0]          count;
    } t_list_result;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [1:0]                 i_op = OP_INS_FRONT;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [1:0]                 o_status;
    logic signed [DATA_W-1:0]   o_removed_value;
    logic [POS_W-1:0]           o_count;

    // Shadow copy of the list, front first, and its length.
    logic signed [DATA_W-1:0]   list_cells [DEPTH];
    int                         list_len = 0;
    t_list_result               pending_results [$];
    int                         mismatch_count = 0;
    int                         idle_pct = 0;
    int                         stall_pct = 0;

    ordered_list_insert_delete_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_count         (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** ordered_list_insert_delete_core: FAILED **");
        $finish;
    end

    // Apply one operation to the shadow list and return the beat it should produce.
    function automatic t_list_result apply_list_op(t_op op, logic signed [DATA_W-1:0] value,
                                                   logic [POS_W-1:0] position);
        t_list_result res;
        int idx;
        int k;
        res.status = ST_OK;
        res.removed = '0;
        idx = -1;
        if (op == OP_INS_FRONT) begin
            if (list_len >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                for (k = list_len; k > 0; k--)
                    list_cells[k] = list_cells[k - 1];
                list_cells[0] = value;
                list_len++;
            end
        end else if (list_len == 0) begin
            res.status = ST_EMPTY;
        end else begin
            if (op == OP_DEL_FRONT)
                idx = 0;
            else if (op == OP_DEL_BACK)
                idx = list_len - 1;
            else if (position != 0 && position <= list_len)
                idx = position - 1;
            if (idx < 0) begin
                res.status = ST_BADPOS;
            end else begin
                res.removed = list_cells[idx];
                for (k = idx; k + 1 < list_len; k++)
                    list_cells[k] = list_cells[k + 1];
                list_len--;
            end
        end
        res.count = POS_W'(list_len);
        return res;
    endfunction

    // Check the result beat taken at this edge, then predict the input beat taken here.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result beat: status %0d removed %0d count %0d",
                                 $realtime, o_status, o_removed_value, o_count);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_removed_value !== want.removed ||
                        o_count !== want.count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch: expected status %0d removed %0d count %0d,",
                                      " got status %0d removed %0d count %0d"},
                                     $realtime, want.status, want.removed, want.count,
                                     o_status, o_removed_value, o_count);
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(apply_list_op(t_op'(i_op), i_value, i_position));
        end
    end

    // Receiver stalls at random with the current rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Present one input beat, after optional idle cycles, and wait until it is taken.
    task automatic send_beat(t_op op, logic signed [DATA_W-1:0] value, logic [POS_W-1:0] position);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_value <= value;
        i_position <= position;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Hold off new beats until every predicted result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    // Every kind of delete on an empty list reports empty.
    task automatic test_empty_list();
        send_beat(OP_DEL_FRONT, $urandom, POS_W'($urandom_range(31)));
        send_beat(OP_DEL_BACK, $urandom, POS_W'($urandom_range(31)));
        send_beat(OP_DEL_POS, $urandom, 5'd1);
        wait_for_results();
    endtask

    // Fill the list, starting with extreme values, then insert once more into the full list.
    task automatic test_fill_to_full();
        logic signed [DATA_W-1:0] corner_values [7];
        int n;
        corner_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1,
                          32'shAAAA_AAAA, 32'sh5555_5555};
        for (n = 0; n < DEPTH; n++) begin
            if (n < 7)
                send_beat(OP_INS_FRONT, corner_values[n], POS_W'($urandom_range(31)));
            else
                send_beat(OP_INS_FRONT, $urandom, POS_W'($urandom_range(31)));
        end
        send_beat(OP_INS_FRONT, $urandom, 5'd0);
        wait_for_results();
    endtask

    // Positions zero and past the end, the first, the last and a middle one, then a back and a front delete.
    task automatic test_position_deletes();
        send_beat(OP_DEL_POS, $urandom, 5'd0);
        send_beat(OP_DEL_POS, $urandom, POS_W'(DEPTH + 1));
        send_beat(OP_DEL_POS, $urandom, 5'd1);
        send_beat(OP_DEL_POS, $urandom, POS_W'(DEPTH - 1));
        send_beat(OP_DEL_POS, $urandom, 5'd7);
        send_beat(OP_DEL_BACK, $urandom, 5'd0);
        send_beat(OP_DEL_FRONT, $urandom, 5'd31);
        wait_for_results();
    endtask

    // Random traffic that sweeps the length between empty and full and back.
    task automatic run_traffic_phase(int idle_rate, int stall_rate, int beats);
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0] position;
        bit filling;
        int pick;
        int n;
        idle_pct = idle_rate;
        stall_pct = stall_rate;
        filling = 1'b1;
        for (n = 0; n < beats; n++) begin
            // Turn around at the ends, and now and then in the middle.
            if (list_len >= DEPTH)
                filling = 1'b0;
            else if (list_len == 0)
                filling = 1'b1;
            else if ($urandom_range(99) < 5)
                filling = !filling;
            if ($urandom_range(9) == 0)
                value = ($urandom_range(1)) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                value = $urandom;
            if ($urandom_range(3) != 0)
                position = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
            else
                position = POS_W'($urandom_range(31));
            pick = $urandom_range(99);
            if (pick < (filling ? 65 : 25))
                send_beat(OP_INS_FRONT, value, position);
            else if (pick < (filling ? 77 : 45))
                send_beat(OP_DEL_FRONT, value, position);
            else if (pick < (filling ? 88 : 65))
                send_beat(OP_DEL_BACK, value, position);
            else
                send_beat(OP_DEL_POS, value, position);
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 170);
        run_traffic_phase(51, 0, 170);
        run_traffic_phase(0, 51, 170);
        run_traffic_phase(38, 38, 170);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_fill_to_full();
        test_position_deletes();
        test_random_traffic();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("** ordered_list_insert_delete_core: PASSED **");
        else
            $display("** ordered_list_insert_delete_core: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/olid_pkg.sv
rtl/olid_cell.sv
rtl/olid_dec.sv
rtl/ordered_list_insert_delete_core.sv
tb/sv/ordered_list_insert_delete_core_test.sv
